/* rtl/hfa_pkg.sv */
package hfa_pkg;

  localparam int LANES_DEF    = 4;
  localparam int SAMPLE_W_DEF = 16;
  localparam int COEFF_W_DEF  = 18;

  localparam int HALF_TAPS   = 25;
  localparam int SPAN        = 50;
  localparam int MID_POS     = 25;
  localparam int TREE_LEVELS = $clog2(HALF_TAPS);
  // line, difference, product, then one stage per adder tree level
  localparam int NUM_STAGES  = 3 + TREE_LEVELS;

  // tap magnitudes scaled by 1e8, outermost tap first
  localparam longint unsigned TAP_E8 [HALF_TAPS] = '{
    64'd1299224,  64'd1354510,  64'd1414711,  64'd1480511,  64'd1552731,
    64'd1632358,  64'd1720594,  64'd1818914,  64'd1929151,  64'd2053612,
    64'd2195241,  64'd2357851,  64'd2546479,  64'd2767912,  64'd3031523,
    64'd3350630,  64'd3744822,  64'd4244132,  64'd4897075,  64'd5787452,
    64'd7073553,  64'd9094568,  64'd12732395, 64'd21220659, 64'd63661977
  };

  // round half up of tap j at cw-1 fraction bits
  function automatic longint unsigned coef_mag(input int j, input int cw);
    longint unsigned scaled;
    scaled = TAP_E8[j] << (cw - 1);
    return (scaled + 64'd50000000) / 64'd100000000;
  endfunction

endpackage

/* rtl/hilbert_fir_analytic_signal.sv */
// channel  | dir | payload (lowest bits first, SW bits each, zero filled to bytes)
// s_axis   | in  | in0_even, in0_odd, in1_even, in1_odd, ... per lane
// m_axis   | out | out0_real, out0_imag, out1_real, out1_imag, ... per lane
//
// Takes one request per clock; every lane runs its own difference, multiply and
// adder tree path, so throughput is set by nothing but downstream ready.
// Order: the accepting edge loads the delay line; then differences, products, the five tree
// levels and the output register each register the request in turn.
// Reset clears the pair delay line and the sign register in the reset cycle itself.
// Stalls: a stage holds only while every stage after it is full, so bubbles close up.
module hilbert_fir_analytic_signal #(
  parameter  int LANES  = hfa_pkg::LANES_DEF,
  parameter  int SW     = hfa_pkg::SAMPLE_W_DEF,
  parameter  int CW     = hfa_pkg::COEFF_W_DEF,
  localparam int DATA_W = ((2 * LANES * SW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,  // in0_even, in0_odd, in1_even, in1_odd, ...
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata   // out0_real, out0_imag, out1_real, ...
);
  import hfa_pkg::*;

  localparam int NST = NUM_STAGES;
  localparam int AW  = SW + CW + 1 + TREE_LEVELS;

  logic [LANES-1:0][SW-1:0]        in_even;
  logic [LANES-1:0][SW-1:0]        in_odd;
  logic [SPAN+LANES-1:0][SW-1:0]   even_line;
  logic [SPAN+LANES-1:0][SW-1:0]   odd_line;
  logic [LANES-1:0]                lane_neg;
  logic [LANES-1:0][AW-1:0]        lane_acc;
  logic [LANES-1:0][SW-1:0]        lane_even;
  logic [LANES-1:0]                lane_sign;
  logic [NST:0]                    rdy;
  logic [NST-1:0]                  vld;
  logic                            load;
  logic                            out_take;

  genvar k;
  for (k = 0; k < LANES; k++) begin : g_unpack
    assign in_even[k] = s_axis_tdata[2*k*SW +: SW];
    assign in_odd[k]  = s_axis_tdata[(2*k+1)*SW +: SW];
  end

  always_comb begin
    rdy[NST] = out_take;
    for (int s = NST - 1; s >= 0; s--) begin
      rdy[s] = !vld[s] || rdy[s+1];
    end
  end

  assign s_axis_tready = rdy[0];
  assign load          = s_axis_tvalid && rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int s = 1; s < NST; s++) begin
        if (rdy[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  hfa_line #(
    .LANES (LANES),
    .SW    (SW)
  ) u_line (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .in_even   (in_even),
    .in_odd    (in_odd),
    .even_line (even_line),
    .odd_line  (odd_line),
    .lane_neg  (lane_neg)
  );

  for (k = 0; k < LANES; k++) begin : g_lane
    hfa_lane #(
      .SW (SW),
      .CW (CW)
    ) u_lane (
      .clk      (clk),
      .en       (rdy[NST-1:1]),
      .odd_win  (odd_line[k +: SPAN]),
      .even_mid (even_line[MID_POS+k]),
      .neg_in   (lane_neg[k]),
      .acc      (lane_acc[k]),
      .even_out (lane_even[k]),
      .neg_out  (lane_sign[k])
    );
  end

  hfa_merge #(
    .LANES (LANES),
    .SW    (SW),
    .CW    (CW)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (vld[NST-1]),
    .take          (out_take),
    .acc           (lane_acc),
    .even          (lane_even),
    .neg           (lane_sign),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    load |=> vld[0])
    else $error("accepted request did not enter the delay line stage");

  a_last_to_out: assert property (@(posedge clk) disable iff (rst)
    (vld[NST-1] && rdy[NST]) |=> m_axis_tvalid)
    else $error("finished request lost before the output register");

  a_head_free: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> s_axis_tready)
    else $error("input blocked while the head stage is empty");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (vld[NST-1] && !rdy[NST]) |=> vld[NST-1])
    else $error("last stage dropped a request while the output was full");

endmodule

/* rtl/hfa_line.sv */
module hfa_line #(
  parameter int LANES = hfa_pkg::LANES_DEF,
  parameter int SW    = hfa_pkg::SAMPLE_W_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       load,
  input  logic [LANES-1:0][SW-1:0]                   in_even,
  input  logic [LANES-1:0][SW-1:0]                   in_odd,
  output logic [hfa_pkg::SPAN+LANES-1:0][SW-1:0]     even_line,
  output logic [hfa_pkg::SPAN+LANES-1:0][SW-1:0]     odd_line,
  output logic [LANES-1:0]                           lane_neg
);
  import hfa_pkg::*;

  logic sgn;

  always_ff @(posedge clk) begin
    if (rst) begin
      even_line <= '0;
      odd_line  <= '0;
      lane_neg  <= '0;
      sgn       <= 1'b0;
    end else if (load) begin
      for (int i = 0; i < SPAN; i++) begin
        even_line[i] <= even_line[i+LANES];
        odd_line[i]  <= odd_line[i+LANES];
      end
      for (int k = 0; k < LANES; k++) begin
        even_line[SPAN+k] <= in_even[k];
        odd_line[SPAN+k]  <= in_odd[k];
        lane_neg[k]       <= sgn ^ 1'(k % 2);
      end
      sgn <= sgn ^ 1'(LANES % 2);
    end
  end

endmodule

/* rtl/hfa_tree.sv */
module hfa_tree #(
  parameter int N  = hfa_pkg::HALF_TAPS,
  parameter int W  = 35,
  parameter int OW = 40
) (
  input  logic                      clk,
  input  logic [$clog2(N)-1:0]      en,
  input  logic [N-1:0][W-1:0]       terms,
  output logic [OW-1:0]             sum
);

  localparam int LEVELS = $clog2(N);

  logic [N-1:0][OW-1:0] base;
  logic [N-1:0][OW-1:0] part [LEVELS];

  genvar l, i;

  for (i = 0; i < N; i++) begin : g_base
    assign base[i] = {{(OW-W){terms[i][W-1]}}, terms[i]};
  end

  for (l = 0; l < LEVELS; l++) begin : g_lvl
    for (i = 0; i < N; i++) begin : g_node
      logic [OW-1:0] a;
      logic [OW-1:0] b;
      if (2*i < N) begin : g_a
        if (l == 0) begin : g_first
          assign a = base[2*i];
        end else begin : g_next
          assign a = part[l-1][2*i];
        end
      end else begin : g_a0
        assign a = '0;
      end
      if (2*i + 1 < N) begin : g_b
        if (l == 0) begin : g_first
          assign b = base[2*i+1];
        end else begin : g_next
          assign b = part[l-1][2*i+1];
        end
      end else begin : g_b0
        assign b = '0;
      end
      always_ff @(posedge clk) begin
        if (en[l]) begin
          part[l][i] <= a + b;
        end
      end
    end
  end

  assign sum = part[LEVELS-1][0];

endmodule

/* rtl/hfa_lane.sv */
module hfa_lane #(
  parameter int SW = hfa_pkg::SAMPLE_W_DEF,
  parameter int CW = hfa_pkg::COEFF_W_DEF
) (
  input  logic                                         clk,
  input  logic [hfa_pkg::NUM_STAGES-2:0]               en,
  input  logic [hfa_pkg::SPAN-1:0][SW-1:0]             odd_win,
  input  logic [SW-1:0]                                even_mid,
  input  logic                                         neg_in,
  output logic [SW+CW+hfa_pkg::TREE_LEVELS:0]          acc,
  output logic [SW-1:0]                                even_out,
  output logic                                         neg_out
);
  import hfa_pkg::*;

  localparam int DW   = SW + 1;
  localparam int PW   = SW + CW + 1;
  localparam int AW   = PW + TREE_LEVELS;
  localparam int SIDE = NUM_STAGES - 1;

  logic [HALF_TAPS-1:0][DW-1:0] diff;
  logic [HALF_TAPS-1:0][PW-1:0] prod;
  logic [SIDE-1:0][SW-1:0]      even_pipe;
  logic [SIDE-1:0]              neg_pipe;

  genvar j;
  for (j = 0; j < HALF_TAPS; j++) begin : g_tap
    localparam logic signed [CW-1:0] MJ = CW'(coef_mag(j, CW));
    always_ff @(posedge clk) begin
      if (en[0]) begin
        diff[j] <= {odd_win[j][SW-1], odd_win[j]}
                 - {odd_win[SPAN-1-j][SW-1], odd_win[SPAN-1-j]};
      end
      if (en[1]) begin
        prod[j] <= $signed(diff[j]) * MJ;
      end
    end
  end

  hfa_tree #(
    .N  (HALF_TAPS),
    .W  (PW),
    .OW (AW)
  ) u_tree (
    .clk   (clk),
    .en    (en[NUM_STAGES-2:2]),
    .terms (prod),
    .sum   (acc)
  );

  always_ff @(posedge clk) begin
    if (en[0]) begin
      even_pipe[0] <= even_mid;
      neg_pipe[0]  <= neg_in;
    end
    for (int s = 1; s < SIDE; s++) begin
      if (en[s]) begin
        even_pipe[s] <= even_pipe[s-1];
        neg_pipe[s]  <= neg_pipe[s-1];
      end
    end
  end

  assign even_out = even_pipe[SIDE-1];
  assign neg_out  = neg_pipe[SIDE-1];

endmodule

/* rtl/hfa_merge.sv */
module hfa_merge #(
  parameter  int LANES  = hfa_pkg::LANES_DEF,
  parameter  int SW     = hfa_pkg::SAMPLE_W_DEF,
  parameter  int CW     = hfa_pkg::COEFF_W_DEF,
  localparam int DATA_W = ((2 * LANES * SW + 7) / 8) * 8
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             in_valid,
  output logic                                             take,
  input  logic [LANES-1:0][SW+CW+hfa_pkg::TREE_LEVELS:0]   acc,
  input  logic [LANES-1:0][SW-1:0]                         even,
  input  logic [LANES-1:0]                                 neg,
  output logic                                             m_axis_tvalid,
  input  logic                                             m_axis_tready,
  output logic [DATA_W-1:0]                                m_axis_tdata
);
  import hfa_pkg::*;

  localparam int AW   = SW + CW + 1 + TREE_LEVELS;
  localparam int FRAC = CW - 1;
  localparam int FW   = AW - FRAC;
  localparam int XW   = FW + 2;
  localparam int PAD  = DATA_W - 2 * LANES * SW;

  localparam logic signed [XW-1:0] SAT_HI = {{(XW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [XW-1:0] SAT_LO = {{(XW-SW+1){1'b1}}, {(SW-1){1'b0}}};

  function automatic logic [SW-1:0] sat(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return r[SW-1:0];
  endfunction

  logic signed [XW-1:0]          re_x [LANES];
  logic signed [XW-1:0]          im_x [LANES];
  logic [LANES-1:0][2*SW-1:0]    lane_word;
  logic [DATA_W-1:0]             data_next;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      re_x[k] = {{(XW-SW-1){even[k][SW-1]}}, even[k], 1'b0};
      im_x[k] = {acc[k][AW-1], acc[k][AW-1:FRAC], 1'b0};
      if (neg[k]) begin
        re_x[k] = -re_x[k];
        im_x[k] = -im_x[k];
      end
      lane_word[k] = {sat(im_x[k]), sat(re_x[k])};
    end
  end

  if (PAD > 0) begin : g_pad
    assign data_next = {{PAD{1'b0}}, lane_word};
  end else begin : g_nopad
    assign data_next = lane_word;
  end

  assign take = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tdata <= data_next;
    end
  end

endmodule
